>>> design/vector3_normalise_assert.svh
// Assertion macros shared by the vector3_normalise RTL.
// Depends on nothing; the macro bodies are empty when SYNTHESIS is defined.
`ifndef VECTOR3_NORMALISE_ASSERT_SVH
`define VECTOR3_NORMALISE_ASSERT_SVH
`ifndef SYNTHESIS
`define VN_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vector3_normalise: same-cycle check failed");
`define VN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vector3_normalise: next-cycle check failed");
`else
`define VN_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define VN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/vn_pkg.sv
// Package for vector3_normalise: widths, payload structs and side-band types.
// Depends on nothing; every design module imports it.
package vn_pkg;
    localparam int VN_IN_W    = 16;
    localparam int VN_FRAC    = 14;
    localparam int VN_OUT_W   = VN_FRAC + 2;
    localparam int VN_LANES   = 3;
    localparam int VN_MAG_W   = VN_IN_W;
    localparam int VN_SQ_W    = 2 * VN_IN_W - 1;
    localparam int VN_SUM_W   = 2 * VN_IN_W;
    localparam int VN_DQ_W    = 2 * VN_FRAC + 1;
    localparam int VN_ROOT_W  = VN_FRAC + 1;
    localparam int VN_REM_W   = VN_FRAC + 4;
    localparam int VN_LAT_LANE = VN_DQ_W + VN_ROOT_W;

    typedef struct packed {
        logic signed [VN_IN_W-1:0] vec_x;
        logic signed [VN_IN_W-1:0] vec_y;
        logic signed [VN_IN_W-1:0] vec_z;
    } t_vec_in;

    typedef struct packed {
        logic signed [VN_OUT_W-1:0] unit_x;
        logic signed [VN_OUT_W-1:0] unit_y;
        logic signed [VN_OUT_W-1:0] unit_z;
        logic                       zero_length;
    } t_vec_out;

    typedef struct packed {
        logic [VN_LANES-1:0] neg;
        logic                zero;
    } t_side;

    typedef struct packed {
        logic [VN_LANES-1:0][VN_SQ_W-1:0] sq;
        logic [VN_SUM_W-1:0]              sum;
        t_side                            side;
    } t_prep;
endpackage

>>> design/vn_prep.sv
// Front stage: magnitudes, squares, sum of squares and sign/zero side band.
// Depends on vn_pkg.
module vn_prep
    import vn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_vec_in i_vec,
    output logic    o_valid,
    output t_prep   o_prep
);
    logic [VN_LANES-1:0][VN_IN_W-1:0]  w_raw;
    logic [VN_LANES-1:0][VN_MAG_W-1:0] w_mag;
    logic [VN_LANES-1:0][VN_SQ_W-1:0]  w_sq;
    logic [VN_SUM_W-1:0]               w_sum;
    t_prep                             n_prep;
    logic                              r_valid;
    t_prep                             r_prep;

    assign w_raw[0] = i_vec.vec_x;
    assign w_raw[1] = i_vec.vec_y;
    assign w_raw[2] = i_vec.vec_z;

    always_comb begin
        for (int i = 0; i < VN_LANES; i++) begin
            // most negative input keeps its full magnitude as unsigned
            w_mag[i] = w_raw[i][VN_IN_W-1] ? (~w_raw[i] + 1'b1) : w_raw[i];
            w_sq[i]  = VN_SQ_W'(w_mag[i] * w_mag[i]);
        end
        w_sum = VN_SUM_W'(w_sq[0]) + VN_SUM_W'(w_sq[1]) + VN_SUM_W'(w_sq[2]);
        n_prep.sq        = w_sq;
        n_prep.sum       = w_sum;
        n_prep.side.neg  = {w_raw[2][VN_IN_W-1], w_raw[1][VN_IN_W-1], w_raw[0][VN_IN_W-1]};
        n_prep.side.zero = (w_sum == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prep <= n_prep;
        end
    end

    assign o_valid = r_valid;
    assign o_prep  = r_prep;
endmodule

>>> design/vn_lane.sv
// One component lane: pipelined long division sq*2^(2F)/sum, then pipelined
// integer square root; one bit per stage. Depends on vn_pkg.
module vn_lane
    import vn_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [VN_SQ_W-1:0]   i_sq,
    input  logic [VN_SUM_W-1:0]  i_sum,
    output logic [VN_ROOT_W-1:0] o_root
);
    logic [VN_SUM_W-1:0]    r_rem  [VN_DQ_W];
    logic [VN_SUM_W-1:0]    r_sum  [VN_DQ_W];
    logic [VN_DQ_W-1:0]     r_quo  [VN_DQ_W];
    logic [VN_REM_W-1:0]    r_srem [VN_ROOT_W];
    logic [VN_ROOT_W-1:0]   r_root [VN_ROOT_W];
    logic [2*VN_ROOT_W-1:0] r_rad  [VN_ROOT_W];

    for (genvar j = 0; j < VN_DQ_W; j++) begin : g_div
        logic [VN_SUM_W:0]   w_t;
        logic [VN_SUM_W-1:0] w_sum_in;
        logic [VN_DQ_W-1:0]  w_quo_in;
        logic                w_ge;
        logic [VN_SUM_W:0]   w_diff;
        if (j == 0) begin : g_first
            // the first stage takes all of sq; every later stage brings in a zero
            assign w_t      = {2'b00, i_sq};
            assign w_sum_in = i_sum;
            assign w_quo_in = '0;
        end else begin : g_rest
            assign w_t      = {r_rem[j-1], 1'b0};
            assign w_sum_in = r_sum[j-1];
            assign w_quo_in = r_quo[j-1];
        end
        assign w_ge   = (w_t >= {1'b0, w_sum_in});
        assign w_diff = w_t - {1'b0, w_sum_in};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= w_ge ? w_diff[VN_SUM_W-1:0] : w_t[VN_SUM_W-1:0];
                r_sum[j] <= w_sum_in;
                r_quo[j] <= {w_quo_in[VN_DQ_W-2:0], w_ge};
            end
        end
    end

    for (genvar s = 0; s < VN_ROOT_W; s++) begin : g_sqrt
        logic [VN_REM_W-1:0]    w_rem_in;
        logic [VN_ROOT_W-1:0]   w_root_in;
        logic [2*VN_ROOT_W-1:0] w_rad_in;
        logic [VN_REM_W-1:0]    w_t;
        logic [VN_REM_W-1:0]    w_trial;
        logic                   w_ge;
        if (s == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = {1'b0, r_quo[VN_DQ_W-1]};
        end else begin : g_rest
            assign w_rem_in  = r_srem[s-1];
            assign w_root_in = r_root[s-1];
            assign w_rad_in  = r_rad[s-1];
        end
        assign w_t     = {w_rem_in[VN_REM_W-3:0], w_rad_in[2*VN_ROOT_W-1-2*s -: 2]};
        assign w_trial = {1'b0, w_root_in, 2'b01};
        assign w_ge    = (w_t >= w_trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_srem[s] <= w_ge ? (w_t - w_trial) : w_t;
                r_root[s] <= {w_root_in[VN_ROOT_W-2:0], w_ge};
                r_rad[s]  <= w_rad_in;
            end
        end
    end

    assign o_root = r_root[VN_ROOT_W-1];
endmodule

>>> design/vn_merge.sv
// Merge stage: applies signs and the zero-vector rule, holds the output register.
// Depends on vn_pkg.
module vn_merge
    import vn_pkg::*;
(
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  t_side                               i_side,
    input  logic [VN_LANES-1:0][VN_ROOT_W-1:0]  i_root,
    output logic                                o_valid,
    output t_vec_out                            o_out
);
    logic [VN_LANES-1:0][VN_OUT_W-1:0] w_unit;
    t_vec_out                          n_out;
    t_vec_out                          r_out;
    logic                              r_valid;

    always_comb begin
        for (int i = 0; i < VN_LANES; i++) begin
            w_unit[i] = VN_OUT_W'(i_root[i]);
            if (i_side.zero) begin
                w_unit[i] = '0;
            end else if (i_side.neg[i]) begin
                w_unit[i] = '0 - w_unit[i];
            end
        end
        n_out.unit_x      = w_unit[0];
        n_out.unit_y      = w_unit[1];
        n_out.unit_z      = w_unit[2];
        n_out.zero_length = i_side.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;
endmodule

>>> design/vector3_normalise.sv
// vector3_normalise: scales a signed 16-bit 3D vector to unit length, giving each
// component in signed Q2.14, truncated toward zero (|u| = floor(|c|*2^14/sqrt(S)),
// S = x*x+y*y+z*z). A zero vector gives zeros with zero_length set. One vector is
// accepted per cycle unless the output stalls; it has one front stage, 29 division
// stages and 15 square-root stages in each of three lanes, and the output register.
// A stalled output freezes the whole pipeline, so input ready follows output ready
// whenever a result is waiting. Depends on vn_pkg, vn_prep, vn_lane and vn_merge.
module vector3_normalise
    import vn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_vec_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_vec_out o_out_data
);
`include "vector3_normalise_assert.svh"

    logic                               w_en;
    logic                               w_prep_valid;
    t_prep                              w_prep;
    logic [VN_LANES-1:0][VN_ROOT_W-1:0] w_root;
    // side band travels alongside the lanes
    logic                               r_vld  [VN_LAT_LANE];
    t_side                              r_side [VN_LAT_LANE];
    logic                               w_units_zero;
    logic                               w_x_in_range;

    // advance everything unless a finished transaction is held at the output
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    vn_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_vec   (i_in_data),
        .o_valid (w_prep_valid),
        .o_prep  (w_prep)
    );

    for (genvar l = 0; l < VN_LANES; l++) begin : g_lane
        vn_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_sq   (w_prep.sq[l]),
            .i_sum  (w_prep.sum),
            .o_root (w_root[l])
        );
    end

    // valid bits are control: reset them; side band is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < VN_LAT_LANE; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= w_prep_valid;
            for (int k = 1; k < VN_LAT_LANE; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= w_prep.side;
            for (int k = 1; k < VN_LAT_LANE; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    vn_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vld[VN_LAT_LANE-1]),
        .i_side  (r_side[VN_LAT_LANE-1]),
        .i_root  (w_root),
        .o_valid (o_out_valid),
        .o_out   (o_out_data)
    );

    assign w_units_zero = (o_out_data.unit_x == '0) && (o_out_data.unit_y == '0)
                          && (o_out_data.unit_z == '0);
    assign w_x_in_range = (o_out_data.unit_x <= 16'sd16384)
                          && (o_out_data.unit_x >= -16'sd16384);

    // a zero vector must come out as all zeros
    `VN_ASSERT_SAME(a_zero_out, i_clk, i_rst_n, o_out_valid && o_out_data.zero_length, w_units_zero)
    // the x result never exceeds one in magnitude
    `VN_ASSERT_SAME(a_range_x, i_clk, i_rst_n, o_out_valid, w_x_in_range)
    // the last lane stage hands its transaction to the output register
    `VN_ASSERT_NEXT(a_drain, i_clk, i_rst_n, w_en && r_vld[VN_LAT_LANE-1], o_out_valid)
    `VN_ASSERT_NEXT(a_bubble, i_clk, i_rst_n, w_en && !r_vld[VN_LAT_LANE-1], !o_out_valid)
endmodule

>>> tb/vn_checker.sv
// Checker for vector3_normalise: watches both channels, predicts unit vectors, compares.
// Depends on vn_pkg; instantiated by tb beside the block.
`timescale 1ns / 100ps
module vn_checker
    import vn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_ready,
    input  t_vec_in  i_in_data,
    input  logic     i_out_valid,
    input  logic     i_out_ready,
    input  t_vec_out i_out_data,
    output int       o_errors,
    output int       o_pending,
    output int       o_results
);
    t_vec_out unit_queue[$];

    // Largest q with q*q*sum <= mag*mag*2^(2F), found bit by bit.
    function automatic logic [VN_OUT_W-1:0] unit_magnitude(logic [63:0] mag,
                                                           logic [63:0] sum);
        logic [127:0] target;
        logic [127:0] trial;
        logic [63:0]  q;
        logic [63:0]  cand;
        target = ({64'd0, mag * mag}) << (2 * VN_FRAC);
        q = 0;
        for (int b = VN_FRAC; b >= 0; b--) begin
            cand = q | (64'd1 << b);
            trial = {64'd0, cand * cand} * {64'd0, sum};
            if (trial <= target) q = cand;
        end
        return q[VN_OUT_W-1:0];
    endfunction

    function automatic t_vec_out unit_vector(t_vec_in v);
        t_vec_out r;
        logic signed [VN_IN_W-1:0] c[3];
        logic [63:0] mag[3];
        logic [63:0] sum;
        logic [VN_OUT_W-1:0] q;
        c[0] = v.vec_x;
        c[1] = v.vec_y;
        c[2] = v.vec_z;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            // Take the full magnitude, the most negative value included.
            mag[i] = c[i][VN_IN_W-1] ? 64'(-(65'(c[i]))) : 64'(c[i]);
            sum += mag[i] * mag[i];
        end
        r = '0;
        if (sum == 0) begin
            r.zero_length = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            q = unit_magnitude(mag[i], sum);
            if (c[i][VN_IN_W-1]) q = -q;
            case (i)
                0: r.unit_x = q;
                1: r.unit_y = q;
                default: r.unit_z = q;
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("checker: %s got %0d expected %0d", what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_results = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_vec_out want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) unit_queue.push_back(unit_vector(i_in_data));
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (unit_queue.size() == 0) begin
                    report_mismatch("unexpected transaction", 1, 0);
                end else begin
                    want = unit_queue.pop_front();
                    if (i_out_data.unit_x !== want.unit_x)
                        report_mismatch("unit_x", i_out_data.unit_x, want.unit_x);
                    if (i_out_data.unit_y !== want.unit_y)
                        report_mismatch("unit_y", i_out_data.unit_y, want.unit_y);
                    if (i_out_data.unit_z !== want.unit_z)
                        report_mismatch("unit_z", i_out_data.unit_z, want.unit_z);
                    if (i_out_data.zero_length !== want.zero_length)
                        report_mismatch("zero_length", i_out_data.zero_length,
                                        want.zero_length);
                end
            end
            o_pending = unit_queue.size();
        end
    end
endmodule

>>> tb/tb.sv
// Testbench top for vector3_normalise: clock, reset, stimulus, receiver stalls, verdict.
// Depends on vn_pkg, the block and vn_checker.
`timescale 1ns / 100ps
module tb;
    import vn_pkg::*;

    localparam int RANDOM_VECTORS = 1130;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 60;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_vec_in  i_in_data;
    logic     o_out_valid;
    logic     i_out_ready;
    t_vec_out o_out_data;
    int       error_count;
    int       pending_count;
    int       result_count;
    int       cycle_count;
    int       vectors_sent;
    bit       hold_off;
    bit       hold_done;

    vector3_normalise i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    vn_checker i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_out_data (o_out_data),
        .o_errors   (error_count),
        .o_pending  (pending_count),
        .o_results  (result_count)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Pick a component: extremes often, small values sometimes, else anything.
    function automatic logic [VN_IN_W-1:0] pick_component();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4, 5: return 16'($signed($urandom_range(0, 40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one transaction and hold it until accepted; valid stays high between
    // back-to-back transactions so it is never dropped and raised in one step.
    task automatic send_vector(logic [VN_IN_W-1:0] x, logic [VN_IN_W-1:0] y,
                               logic [VN_IN_W-1:0] z, bit no_gap);
        int gap;
        gap = no_gap ? 0 : gap_length();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{vec_x: x, vec_y: y, vec_z: z};
        do @(posedge i_clk); while (!o_in_ready);
        vectors_sent++;
    endtask

    // Directed extremes: axes, most negative values, zero vector, sign mixes.
    task automatic send_directed();
        send_vector(16'd0, 16'd0, 16'd0, 1);
        send_vector(16'd1, 16'd0, 16'd0, 1);
        send_vector(16'd0, 16'hffff, 16'd0, 1);
        send_vector(16'd0, 16'd0, 16'h7fff, 1);
        send_vector(16'h8000, 16'd0, 16'd0, 1);
        send_vector(16'd0, 16'h8000, 16'd0, 1);
        send_vector(16'd0, 16'd0, 16'h8000, 1);
        send_vector(16'h8000, 16'h8000, 16'h8000, 1);
        send_vector(16'h7fff, 16'h7fff, 16'h7fff, 1);
        send_vector(16'h7fff, 16'h8000, 16'h7fff, 1);
        send_vector(16'd1, 16'd1, 16'd1, 1);
        send_vector(16'hffff, 16'hffff, 16'hffff, 1);
        send_vector(16'd3, 16'd4, 16'd0, 1);
        send_vector(16'd2, 16'hfffe, 16'd1, 1);
        send_vector(16'h8000, 16'd1, 16'd0, 1);
        send_vector(16'd1, 16'h7fff, 16'h8000, 1);
        send_vector(16'h5555, 16'haaaa, 16'h0f0f, 1);
        send_vector(16'haaaa, 16'h5555, 16'hf0f0, 1);
        send_vector(16'd0, 16'd0, 16'd0, 1);
    endtask

    // Receiver: random stalls, plus one long hold-off while the sender keeps going.
    initial begin
        i_out_ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
                hold_done = 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 3) != 0) || (result_count < 40);
                @(posedge i_clk);
                if (gap_length() > 6) begin
                    i_out_ready <= 1'b0;
                    repeat ($urandom_range(8, 40)) @(posedge i_clk);
                end
            end
        end
    end

    // Cycle limit: stop a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int drain;
        cycle_count = 0;
        vectors_sent = 0;
        hold_off = 1'b0;
        hold_done = 1'b0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed();
        for (int n = 0; n < RANDOM_VECTORS; n++) begin
            // Halfway through, hold the receiver off and stream back to back.
            if (n == RANDOM_VECTORS / 2) hold_off = 1'b1;
            send_vector(pick_component(), pick_component(), pick_component(),
                        hold_off || ($urandom_range(0, 4) == 0));
        end
        i_in_valid <= 1'b0;

        // wait until every accepted transaction has come back
        wait (result_count >= vectors_sent && pending_count == 0);
        drain = 0;
        while (drain < DRAIN_CYCLES) begin
            @(posedge i_clk);
            drain++;
        end
        $display("sent %0d vectors (%0d directed), checked %0d results, long stall %s",
                 vectors_sent, 19, result_count, hold_done ? "done" : "skipped");
        if (error_count == 0 && result_count == vectors_sent) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", error_count);
            $display("tb: failure");
        end
        $finish;
    end
endmodule
